// ----- rtl/svl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_pkg
// Shared codes for the stereo letterbox viewport: layouts, register indexes
// and the constants of the divide-by-49 used for frame packing.
// ----------------------------------------------------------------------------
package svl_pkg;

	localparam logic [3:0] LAYOUT_MONO      = 4'd0;
	localparam logic [3:0] LAYOUT_LR        = 4'd1;
	localparam logic [3:0] LAYOUT_LR_HALF   = 4'd2;
	localparam logic [3:0] LAYOUT_TB        = 4'd3;
	localparam logic [3:0] LAYOUT_TB_HALF   = 4'd4;
	localparam logic [3:0] LAYOUT_FRAMEPACK = 4'd5;
	localparam logic [3:0] LAYOUT_ROWS      = 4'd6;
	localparam logic [3:0] LAYOUT_COLS      = 4'd7;
	localparam logic [3:0] LAYOUT_CHECKER   = 4'd8;

	localparam logic [2:0] REG_LAYOUT = 3'd0;
	localparam logic [2:0] REG_CROP   = 3'd1;
	localparam logic [2:0] REG_ZOOM   = 3'd2;
	localparam logic [2:0] REG_PIXEL  = 3'd3;

	// h/49 ~ (h*1337)>>16, low by at most one for h below 2^16
	localparam int BLANK_DIV   = 49;
	localparam int RECIP_MUL   = 1337;
	localparam int RECIP_SHIFT = 16;

endpackage

// ----- rtl/svl_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_queue
// Two-entry queue between the classifying front and the fit sequencer.
// ----------------------------------------------------------------------------
module svl_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         nonempty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
`endif

endmodule

// ----- rtl/svl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_front
// Classifies an item by stereo layout: view box, adjusted aspects, view
// offsets and even-size flags, packed for the queue.
// ----------------------------------------------------------------------------
module svl_front #(
	parameter int C  = 14,
	parameter int F  = 16,
	parameter int AR = F + 8,
	parameter int EW = 3 + 6 * C + 2 * AR
) (
	input  logic [3:0]    layout,
	input  logic [AR-1:0] crop,
	input  logic [C-1:0]  w,
	input  logic [C-1:0]  h,
	input  logic [AR-1:0] s,
	input  logic          frame_valid,
	output logic [EW-1:0] entry
);

	logic [C+10:0] rprod;
	logic [C-1:0]  q0;
	logic [C+5:0]  rem;
	logic [C-1:0]  blank;
	logic [C-1:0]  bw, bh, sx_off, fy_off;
	logic [AR-1:0] s2, c2;
	logic [AR:0]   s_dbl, c_dbl;
	logic          even_w, even_h;

	// frame packing blank lines by reciprocal multiply and one correction
	always_comb begin
		rprod = (C+11)'(h) * (C+11)'(svl_pkg::RECIP_MUL);
		q0    = C'(rprod >> svl_pkg::RECIP_SHIFT);
		rem   = (C+6)'(h) - (C+6)'(q0) * (C+6)'(svl_pkg::BLANK_DIV);
		blank = (rem >= (C+6)'(svl_pkg::BLANK_DIV)) ? q0 + C'(1) : q0;
	end

	always_comb begin
		s_dbl  = {s, 1'b0};
		c_dbl  = {crop, 1'b0};
		bw     = w;
		bh     = h;
		s2     = s;
		c2     = crop;
		sx_off = '0;
		fy_off = '0;
		case (layout)
			svl_pkg::LAYOUT_LR, svl_pkg::LAYOUT_LR_HALF: begin
				bw     = w >> 1;
				sx_off = w >> 1;
				if (layout == svl_pkg::LAYOUT_LR_HALF) begin
					s2 = s >> 1;
					c2 = crop >> 1;
				end
			end
			svl_pkg::LAYOUT_TB, svl_pkg::LAYOUT_TB_HALF: begin
				bh     = h >> 1;
				fy_off = h >> 1;
				if (layout == svl_pkg::LAYOUT_TB_HALF) begin
					s2 = s_dbl[AR] ? '1 : s_dbl[AR-1:0];
					c2 = c_dbl[AR] ? '1 : c_dbl[AR-1:0];
				end
			end
			svl_pkg::LAYOUT_FRAMEPACK: begin
				bh     = (h - blank) >> 1;
				fy_off = ((h - blank) >> 1) + blank;
			end
			default: ;
		endcase
		even_w = (layout == svl_pkg::LAYOUT_COLS) || (layout == svl_pkg::LAYOUT_CHECKER);
		even_h = (layout == svl_pkg::LAYOUT_ROWS) || (layout == svl_pkg::LAYOUT_CHECKER);
	end

	assign entry = {frame_valid, even_w, even_h, w, h, bw, bh, sx_off, fy_off, s2, c2};

endmodule

// ----- rtl/svl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svl_div #(
	parameter int NW = 40,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          qbit;

	assign done = done_q;
	assign quot = quo_q;

	always_comb begin
		rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
		qbit   = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
				cnt_q  <= CW'(NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= qbit ? rem_sh - {1'b0, den_q} : rem_sh;
				quo_q <= {quo_q[NW-2:0], qbit};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/svl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svl_back
// Fit sequencer: box aspect, crop, zoom blend and centring through one shared
// divider, with a result register toward the output channel.
// ----------------------------------------------------------------------------
module svl_back #(
	parameter int C  = 14,
	parameter int F  = 16,
	parameter int AR = F + 8,
	parameter int EW = 3 + 6 * C + 2 * AR
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [EW-1:0] entry,
	input  logic          q_nonempty,
	output logic          q_pop,
	input  logic [AR-1:0] pix,
	input  logic [F:0]    zoom,
	output logic          result_valid,
	input  logic          result_stall,
	output logic [C-1:0]  first_x,
	output logic [C-1:0]  first_y,
	output logic [C-1:0]  view_w,
	output logic [C-1:0]  view_h,
	output logic [C-1:0]  second_x,
	output logic [C-1:0]  second_y,
	output logic [F-1:0]  u_cut,
	output logic [F-1:0]  v_cut
);

	localparam int MW = (C > F) ? C : F;
	localparam int NW = AR + MW;
	localparam int UW = F + 1;
	localparam logic [AR-1:0] AR_MAX = '1;
	localparam logic [UW-1:0] ONE    = UW'(1) << F;
	localparam logic [UW-1:0] HALF   = UW'(1) << (F - 1);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_D    = 8'b0000_0010,
		ST_CROP = 8'b0000_0100,
		ST_FIT  = 8'b0000_1000,
		ST_ZS   = 8'b0001_0000,
		ST_ZC   = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		OP_D    = 3'd0,
		OP_CROP = 3'd1,
		OP_VH   = 3'd2,
		OP_VW   = 3'd3,
		OP_ZC   = 3'd4
	} op_t;

	logic          e_valid, e_evw, e_evh;
	logic [C-1:0]  e_w, e_h, e_bw, e_bh, e_sx, e_fy;
	logic [AR-1:0] e_s, e_c;

	state_t        state_q;
	op_t           op_q;
	logic          start_q;
	logic          valid_q, evw_q, evh_q;
	logic [C-1:0]  w_q, h_q, bw_q, bh_q, sxo_q, fyo_q, vw_q, vh_q;
	logic [AR-1:0] s_q, c_q, d_q, zs_q;
	logic [NW-1:0] num_q;
	logic [AR-1:0] den_q;
	logic [AR+UW-1:0] prod_q;
	logic [UW-1:0] ucut_q;
	logic [F-1:0]  vcut_q;

	logic          div_done;
	logic [NW-1:0] quot;
	logic [UW-1:0] zoom_c;
	logic [AR-1:0] zs_c;
	logic [F-1:0]  rf;
	logic [C-1:0]  vw_e, vh_e, x_c, y_c;
	logic [UW-1:0] uc_c;
	logic          out_free;

	logic          rv_q;
	logic [C-1:0]  fx_q, fy_q, vwo_q, vho_q, sx_q, sy_q;
	logic [F-1:0]  uo_q, vo_q;

	assign {e_valid, e_evw, e_evh, e_w, e_h, e_bw, e_bh, e_sx, e_fy, e_s, e_c} = entry;

	svl_div #(.NW(NW), .DW(AR)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (quot)
	);

	// (1 - q)/2 in Q0.F, q clamped to 1.0
	function automatic logic [F-1:0] ratio_cut(input logic [NW-1:0] q);
		logic [UW-1:0] qc;
		qc = (q > NW'(ONE)) ? ONE : q[UW-1:0];
		return F'((ONE - qc) >> 1);
	endfunction

	always_comb begin
		zoom_c   = zoom[F] ? ONE : zoom;
		zs_c     = s_q - AR'(prod_q >> F);
		rf       = ratio_cut(quot);
		vw_e     = (evw_q && vw_q > C'(1) && vw_q[0]) ? vw_q - C'(1) : vw_q;
		vh_e     = (evh_q && vh_q > C'(1) && vh_q[0]) ? vh_q - C'(1) : vh_q;
		x_c      = (bw_q - vw_e) >> 1;
		y_c      = (bh_q - vh_e) >> 1;
		uc_c     = (ucut_q > HALF) ? HALF : ucut_q;
		out_free = !rv_q || !result_stall;
		q_pop    = (state_q == ST_IDLE) && q_nonempty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			rv_q    <= 1'b0;
		end else begin
			// start is only ever high for the first cycle in the divide wait
			if (start_q) begin
				start_q <= 1'b0;
			end
			if (state_q == ST_FIN && out_free) begin
				rv_q <= 1'b1;
			end else if (!result_stall) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_nonempty) begin
						valid_q <= e_valid;
						evw_q   <= e_evw;
						evh_q   <= e_evh;
						w_q     <= e_w;
						h_q     <= e_h;
						bw_q    <= e_bw;
						bh_q    <= e_bh;
						sxo_q   <= e_sx;
						fyo_q   <= e_fy;
						s_q     <= e_s;
						c_q     <= e_c;
						ucut_q  <= '0;
						vcut_q  <= '0;
						state_q <= ST_D;
					end
				end
				ST_D: begin
					if (!valid_q) begin
						state_q <= ST_FIN;
					end else if (bh_q == '0) begin
						d_q     <= AR_MAX;
						state_q <= ST_CROP;
					end else begin
						num_q   <= NW'(bw_q) * NW'(pix);
						den_q   <= AR'(bh_q);
						op_q    <= OP_D;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_CROP: begin
					if (c_q != '0) begin
						if (s_q >= c_q) begin
							num_q <= NW'(c_q) << F;
							den_q <= s_q;
						end else begin
							num_q <= NW'(s_q) << F;
							den_q <= c_q;
						end
						op_q    <= OP_CROP;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIT;
					end
				end
				ST_FIT: begin
					if (s_q >= d_q) begin
						prod_q  <= (AR+UW)'(s_q - d_q) * (AR+UW)'(zoom_c);
						vw_q    <= bw_q;
						state_q <= ST_ZS;
					end else begin
						num_q   <= NW'(s_q) * NW'(bw_q);
						den_q   <= d_q;
						op_q    <= OP_VW;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_ZS: begin
					zs_q <= zs_c;
					if (zs_c == '0) begin
						vh_q    <= bh_q;
						state_q <= ST_ZC;
					end else begin
						num_q   <= NW'(d_q) * NW'(bh_q);
						den_q   <= zs_c;
						op_q    <= OP_VH;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_ZC: begin
					if (s_q != '0) begin
						num_q   <= NW'(zs_q) << F;
						den_q   <= s_q;
						op_q    <= OP_ZC;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						case (op_q)
							OP_D: begin
								d_q     <= (|quot[NW-1:AR]) ? AR_MAX : quot[AR-1:0];
								state_q <= ST_CROP;
							end
							OP_CROP: begin
								if (s_q >= c_q) begin
									ucut_q <= UW'(rf);
								end else begin
									vcut_q <= rf;
								end
								s_q     <= c_q;
								state_q <= ST_FIT;
							end
							OP_VH: begin
								vh_q    <= (quot > NW'(bh_q)) ? bh_q : quot[C-1:0];
								state_q <= ST_ZC;
							end
							OP_VW: begin
								vw_q    <= (quot > NW'(bw_q)) ? bw_q : quot[C-1:0];
								vh_q    <= bh_q;
								state_q <= ST_FIN;
							end
							OP_ZC: begin
								ucut_q  <= ucut_q + UW'(rf);
								state_q <= ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (!valid_q) begin
							fx_q  <= '0;
							fy_q  <= '0;
							vwo_q <= w_q;
							vho_q <= h_q;
							sx_q  <= '0;
							sy_q  <= '0;
							uo_q  <= '0;
							vo_q  <= '0;
						end else begin
							fx_q  <= x_c;
							fy_q  <= y_c + fyo_q;
							vwo_q <= vw_e;
							vho_q <= vh_e;
							sx_q  <= x_c + sxo_q;
							sy_q  <= y_c;
							uo_q  <= uc_c[F-1:0];
							vo_q  <= vcut_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = rv_q;
	assign first_x      = fx_q;
	assign first_y      = fy_q;
	assign view_w       = vwo_q;
	assign view_h       = vho_q;
	assign second_x     = sx_q;
	assign second_y     = sy_q;
	assign u_cut        = uo_q;
	assign v_cut        = vo_q;

`ifndef NO_ASSERTIONS
	a_ucut_half: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q |-> (uo_q <= HALF[F-1:0]))
		else $error("u_cut above one half");
	a_vcut_half: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q |-> (vo_q <= HALF[F-1:0]))
		else $error("v_cut above one half");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide wait");
`endif

endmodule

// ----- rtl/stereo_letterbox_viewport.sv -----
`timescale 1ns / 1ps
// An invalid frame takes no divide; a valid frame takes one to four divides,
// all in one shared radix-2 divider, and the fit sequencer takes one item at
// a time; a two-entry queue and the result register let input and output stall
// independently.
// Reset: asynchronous active-low; registers return to mono, no crop, no zoom,
// pixel aspect 1.0; queue and result register empty.
// ----------------------------------------------------------------------------
// stereo_letterbox_viewport
// Splits a window by stereo layout and fits the source aspect into each view
// with optional crop and zoom blend, giving two view rectangles and cuts.
// ----------------------------------------------------------------------------
module stereo_letterbox_viewport #(
	parameter int COORD_BITS = 14,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [FRAC_BITS+7:0]    cfg_data,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic [COORD_BITS-1:0]   window_width,
	input  logic [COORD_BITS-1:0]   window_height,
	input  logic [FRAC_BITS+7:0]    source_aspect,
	input  logic                    frame_valid,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [COORD_BITS-1:0]   first_x,
	output logic [COORD_BITS-1:0]   first_y,
	output logic [COORD_BITS-1:0]   view_w,
	output logic [COORD_BITS-1:0]   view_h,
	output logic [COORD_BITS-1:0]   second_x,
	output logic [COORD_BITS-1:0]   second_y,
	output logic [FRAC_BITS-1:0]    u_cut,
	output logic [FRAC_BITS-1:0]    v_cut
);

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int AR = F + 8;
	localparam int EW = 3 + 6 * C + 2 * AR;

	logic [3:0]    layout_q;
	logic [AR-1:0] crop_q;
	logic [F:0]    zoom_q;
	logic [AR-1:0] pix_q;

	logic [EW-1:0] f_entry, q_entry;
	logic          q_full, q_nonempty, q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= svl_pkg::LAYOUT_MONO;
			crop_q   <= '0;
			zoom_q   <= '0;
			pix_q    <= AR'(1) << F;
		end else if (cfg_we) begin
			case (cfg_index)
				svl_pkg::REG_LAYOUT: layout_q <= cfg_data[3:0];
				svl_pkg::REG_CROP:   crop_q   <= cfg_data;
				svl_pkg::REG_ZOOM:   zoom_q   <= cfg_data[F:0];
				svl_pkg::REG_PIXEL:  pix_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	svl_front #(.C(C), .F(F), .AR(AR), .EW(EW)) u_front (
		.layout      (layout_q),
		.crop        (crop_q),
		.w           (window_width),
		.h           (window_height),
		.s           (source_aspect),
		.frame_valid (frame_valid),
		.entry       (f_entry)
	);

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;

	svl_queue #(.W(EW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (f_entry),
		.pop      (q_pop),
		.rdata    (q_entry),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	svl_back #(.C(C), .F(F), .AR(AR), .EW(EW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry        (q_entry),
		.q_nonempty   (q_nonempty),
		.q_pop        (q_pop),
		.pix          (pix_q),
		.zoom         (zoom_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.first_x      (first_x),
		.first_y      (first_y),
		.view_w       (view_w),
		.view_h       (view_h),
		.second_x     (second_x),
		.second_y     (second_y),
		.u_cut        (u_cut),
		.v_cut        (v_cut)
	);

endmodule
